[hw/rtl/rlfp_pkg.sv]
// ----------------------------------------------------------------------------
// rlfp_pkg
// Shared types and sizing for the reference-counted latest-frame pool.
// ----------------------------------------------------------------------------
`default_nettype none

package rlfp_pkg;

   localparam int SLOTS    = 4;
   localparam int REF_BITS = 8;
   localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int BUSY_W   = $clog2(SLOTS + 1);

   typedef logic [SLOT_W-1:0]   slot_type;
   typedef logic [REF_BITS-1:0] count_type;
   typedef logic [31:0]         seq_type;
   typedef logic [BUSY_W-1:0]   busy_type;

   typedef enum logic [1:0] {
      OP_ACQUIRE = 2'd0,
      OP_PUBLISH = 2'd1,
      OP_CLAIM   = 2'd2,
      OP_RELEASE = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK            = 3'd0,
      ST_NO_FREE       = 3'd1,
      ST_NOTHING_NEWER = 3'd2,
      ST_UNDERFLOW     = 3'd3,
      ST_OVERFLOW      = 3'd4
   } status_type;

endpackage

`default_nettype wire

[hw/rtl/refcounted_latest_frame_pool.sv]
// ----------------------------------------------------------------------------
// refcounted_latest_frame_pool
// Frame slot pool with reference counts, latest-frame tracking and statistics.
// ----------------------------------------------------------------------------
// One request gives one response. A request is registered on transfer and is
// processed once the response register is free or being emptied; the slot
// state is updated in that same cycle, so the next request sees it. Throughput
// is one request per cycle while the receiver does not stall. A request passes
// through the request register, then the slot search and count update, then
// the response register. Status and counters in a response reflect state after
// the request.
// ----------------------------------------------------------------------------
`default_nettype none

module refcounted_latest_frame_pool (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_operation,
   input  wire logic [1:0]  req_slot_index,
   input  wire logic [31:0] req_newer_than,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_status,
   output logic [1:0]       rsp_granted_slot,
   output logic [31:0]      rsp_granted_seq,
   output logic [2:0]       rsp_slots_busy,
   output logic [31:0]      rsp_publishes_total,
   output logic [31:0]      rsp_acquire_misses
);

   // request register
   logic        in_valid_ff, in_valid_in;
   logic [1:0]  op_ff;
   logic [1:0]  idx_ff;
   logic [31:0] newer_ff;

   // pool state
   rlfp_pkg::count_type ref_counts_ff [rlfp_pkg::SLOTS];
   rlfp_pkg::count_type ref_counts_in [rlfp_pkg::SLOTS];
   rlfp_pkg::seq_type   slot_seqs_ff  [rlfp_pkg::SLOTS];
   rlfp_pkg::seq_type   slot_seqs_in  [rlfp_pkg::SLOTS];
   logic                latest_valid_ff, latest_valid_in;
   rlfp_pkg::slot_type  latest_slot_ff, latest_slot_in;
   rlfp_pkg::seq_type   seq_counter_ff, seq_counter_in;
   rlfp_pkg::seq_type   publish_tally_ff, publish_tally_in;
   rlfp_pkg::seq_type   miss_tally_ff, miss_tally_in;

   // response register
   logic                rsp_valid_ff, rsp_valid_in;
   rlfp_pkg::status_type status_ff, status_in;
   logic [1:0]          gslot_ff, gslot_in;
   rlfp_pkg::seq_type   gseq_ff, gseq_in;
   rlfp_pkg::busy_type  busy_ff, busy_in;

   logic                advance;
   logic                idx_ok;
   rlfp_pkg::slot_type  idx;
   rlfp_pkg::op_type    op;
   logic                acq_found;
   rlfp_pkg::slot_type  acq_slot;

   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign in_valid_in = (req_valid && !req_stall) || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   assign op     = rlfp_pkg::op_type'(op_ff);
   assign idx_ok = 32'(idx_ff) < 32'(rlfp_pkg::SLOTS);
   assign idx    = rlfp_pkg::slot_type'(idx_ff);

   // lowest free slot
   always_comb begin
      acq_found = 1'b0;
      acq_slot  = '0;
      for (int i = rlfp_pkg::SLOTS - 1; i >= 0; i--) begin
         if (ref_counts_ff[i] == '0) begin
            acq_found = 1'b1;
            acq_slot  = rlfp_pkg::slot_type'(i);
         end
      end
   end

   always_comb begin
      rlfp_pkg::count_type lc;
      rlfp_pkg::count_type ic;
      rlfp_pkg::seq_type   ls;
      ref_counts_in    = ref_counts_ff;
      slot_seqs_in     = slot_seqs_ff;
      latest_valid_in  = latest_valid_ff;
      latest_slot_in   = latest_slot_ff;
      seq_counter_in   = seq_counter_ff;
      publish_tally_in = publish_tally_ff;
      miss_tally_in    = miss_tally_ff;
      status_in        = rlfp_pkg::ST_OK;
      gslot_in         = 2'd0;
      gseq_in          = '0;
      lc = ref_counts_ff[latest_slot_ff];
      ic = ref_counts_ff[idx];
      ls = slot_seqs_ff[latest_slot_ff];
      unique case (op)
         rlfp_pkg::OP_ACQUIRE: begin
            if (acq_found) begin
               ref_counts_in[acq_slot] = rlfp_pkg::count_type'(1);
               gslot_in = 2'(acq_slot);
            end else begin
               status_in     = rlfp_pkg::ST_NO_FREE;
               miss_tally_in = miss_tally_ff + 32'd1;
            end
         end
         rlfp_pkg::OP_PUBLISH: begin
            if (idx_ok) begin
               seq_counter_in    = seq_counter_ff + 32'd1;
               slot_seqs_in[idx] = seq_counter_ff + 32'd1;
               if (latest_valid_ff) begin
                  if (lc == '0) begin
                     status_in = rlfp_pkg::ST_UNDERFLOW;
                  end else begin
                     ref_counts_in[latest_slot_ff] = lc - rlfp_pkg::count_type'(1);
                  end
               end
               latest_slot_in   = idx;
               latest_valid_in  = 1'b1;
               publish_tally_in = publish_tally_ff + 32'd1;
               gseq_in          = seq_counter_ff + 32'd1;
            end
         end
         rlfp_pkg::OP_CLAIM: begin
            if (latest_valid_ff && (newer_ff == '0 || ls > newer_ff)) begin
               if (lc == '1) begin
                  status_in = rlfp_pkg::ST_OVERFLOW;
               end else begin
                  ref_counts_in[latest_slot_ff] = lc + rlfp_pkg::count_type'(1);
                  gslot_in = 2'(latest_slot_ff);
                  gseq_in  = ls;
               end
            end else begin
               status_in = rlfp_pkg::ST_NOTHING_NEWER;
            end
         end
         rlfp_pkg::OP_RELEASE: begin
            if (idx_ok) begin
               if (ic == '0) begin
                  status_in = rlfp_pkg::ST_UNDERFLOW;
               end else begin
                  ref_counts_in[idx] = ic - rlfp_pkg::count_type'(1);
               end
            end
         end
         default: begin
            status_in = rlfp_pkg::ST_OK;
         end
      endcase
   end

   always_comb begin
      busy_in = '0;
      for (int i = 0; i < rlfp_pkg::SLOTS; i++) begin
         busy_in = busy_in + rlfp_pkg::busy_type'(ref_counts_in[i] != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         latest_valid_ff  <= 1'b0;
         latest_slot_ff   <= '0;
         seq_counter_ff   <= '0;
         publish_tally_ff <= '0;
         miss_tally_ff    <= '0;
         for (int i = 0; i < rlfp_pkg::SLOTS; i++) begin
            ref_counts_ff[i] <= '0;
            slot_seqs_ff[i]  <= '0;
         end
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            ref_counts_ff    <= ref_counts_in;
            slot_seqs_ff     <= slot_seqs_in;
            latest_valid_ff  <= latest_valid_in;
            latest_slot_ff   <= latest_slot_in;
            seq_counter_ff   <= seq_counter_in;
            publish_tally_ff <= publish_tally_in;
            miss_tally_ff    <= miss_tally_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         op_ff    <= req_operation;
         idx_ff   <= req_slot_index;
         newer_ff <= req_newer_than;
      end
      if (advance) begin
         status_ff <= status_in;
         gslot_ff  <= gslot_in;
         gseq_ff   <= gseq_in;
         busy_ff   <= busy_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = status_ff;
   assign rsp_granted_slot    = gslot_ff;
   assign rsp_granted_seq     = gseq_ff;
   assign rsp_slots_busy      = 3'(busy_ff);
   assign rsp_publishes_total = publish_tally_ff;
   assign rsp_acquire_misses  = miss_tally_ff;

   // checks
   a_acquire_sets_one: assert property (@(posedge clock) disable iff (reset)
      advance && op == rlfp_pkg::OP_ACQUIRE && acq_found
      |=> ref_counts_ff[$past(acq_slot)] == rlfp_pkg::count_type'(1))
      else $error("acquired slot count not one");

   a_publish_latest: assert property (@(posedge clock) disable iff (reset)
      advance && op == rlfp_pkg::OP_PUBLISH && idx_ok
      |=> latest_valid_ff && latest_slot_ff == $past(idx))
      else $error("publish did not update latest slot");

   a_seq_only_on_publish: assert property (@(posedge clock) disable iff (reset)
      !(advance && op == rlfp_pkg::OP_PUBLISH) |=> $stable(seq_counter_ff))
      else $error("sequence counter moved without publish");

   a_miss_tally: assert property (@(posedge clock) disable iff (reset)
      advance && op == rlfp_pkg::OP_ACQUIRE && !acq_found
      |=> miss_tally_ff == $past(miss_tally_ff) + 32'd1)
      else $error("failed acquire not counted");

endmodule

`default_nettype wire

[dv/rlfp_monitor.sv]
// ----------------------------------------------------------------------------
// rlfp_monitor
// Watches both channels of the frame pool, predicts each response from its
// own copy of the slot state and compares every transfer field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module rlfp_monitor (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic [1:0]  req_operation,
   input  wire logic [1:0]  req_slot_index,
   input  wire logic [31:0] req_newer_than,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic [2:0]  rsp_status,
   input  wire logic [1:0]  rsp_granted_slot,
   input  wire logic [31:0] rsp_granted_seq,
   input  wire logic [2:0]  rsp_slots_busy,
   input  wire logic [31:0] rsp_publishes_total,
   input  wire logic [31:0] rsp_acquire_misses,
   output int unsigned      mismatches,
   output int unsigned      responses_checked
);

   typedef struct {
      rlfp_pkg::status_type status;
      rlfp_pkg::slot_type   slot;
      rlfp_pkg::seq_type    seq;
      rlfp_pkg::busy_type   busy;
      rlfp_pkg::seq_type    pubs;
      rlfp_pkg::seq_type    misses;
   } pool_rsp_type;

   rlfp_pkg::count_type slot_refs [rlfp_pkg::SLOTS];
   rlfp_pkg::seq_type   slot_stamps [rlfp_pkg::SLOTS];
   logic                latest_ok;
   rlfp_pkg::slot_type  latest_idx;
   rlfp_pkg::seq_type   stamp_counter;
   rlfp_pkg::seq_type   pub_tally;
   rlfp_pkg::seq_type   miss_count;

   pool_rsp_type awaited_rsps [$];

   task automatic flag(input string msg);
      $display("[%0t] response %0d: %s", $realtime, responses_checked, msg);
      mismatches++;
   endtask

   task automatic drop_ref(input rlfp_pkg::slot_type s, output rlfp_pkg::status_type st);
      if (slot_refs[s] == '0) begin
         st = rlfp_pkg::ST_UNDERFLOW;
      end else begin
         slot_refs[s] = slot_refs[s] - rlfp_pkg::count_type'(1);
         st = rlfp_pkg::ST_OK;
      end
   endtask

   task automatic apply_request(input rlfp_pkg::op_type op, input rlfp_pkg::slot_type idx,
                                input rlfp_pkg::seq_type nt, output pool_rsp_type r);
      logic found;
      int   n;
      r.status = rlfp_pkg::ST_OK;
      r.slot   = '0;
      r.seq    = '0;
      found    = 1'b0;
      n        = 0;
      case (op)
         rlfp_pkg::OP_ACQUIRE: begin
            for (int i = 0; i < rlfp_pkg::SLOTS; i++) begin
               if (!found && slot_refs[i] == '0) begin
                  slot_refs[i] = rlfp_pkg::count_type'(1);
                  r.slot       = rlfp_pkg::slot_type'(i);
                  found        = 1'b1;
               end
            end
            if (!found) begin
               r.status   = rlfp_pkg::ST_NO_FREE;
               miss_count = miss_count + 32'd1;
            end
         end
         rlfp_pkg::OP_PUBLISH: begin
            stamp_counter    = stamp_counter + 32'd1;
            slot_stamps[idx] = stamp_counter;
            if (latest_ok)
               drop_ref(latest_idx, r.status);
            latest_idx = idx;
            latest_ok  = 1'b1;
            pub_tally  = pub_tally + 32'd1;
            r.seq      = stamp_counter;
         end
         rlfp_pkg::OP_CLAIM: begin
            if (latest_ok && (nt == '0 || slot_stamps[latest_idx] > nt)) begin
               if (slot_refs[latest_idx] == '1) begin
                  r.status = rlfp_pkg::ST_OVERFLOW;
               end else begin
                  slot_refs[latest_idx] = slot_refs[latest_idx] + rlfp_pkg::count_type'(1);
                  r.slot = latest_idx;
                  r.seq  = slot_stamps[latest_idx];
               end
            end else begin
               r.status = rlfp_pkg::ST_NOTHING_NEWER;
            end
         end
         default: drop_ref(idx, r.status);
      endcase
      for (int i = 0; i < rlfp_pkg::SLOTS; i++)
         if (slot_refs[i] != '0)
            n++;
      r.busy   = rlfp_pkg::busy_type'(n);
      r.pubs   = pub_tally;
      r.misses = miss_count;
   endtask

   always @(posedge clock) begin
      pool_rsp_type want;
      if (reset) begin
         for (int i = 0; i < rlfp_pkg::SLOTS; i++) begin
            slot_refs[i]   = '0;
            slot_stamps[i] = '0;
         end
         latest_ok     = 1'b0;
         latest_idx    = '0;
         stamp_counter = '0;
         pub_tally     = '0;
         miss_count    = '0;
         awaited_rsps.delete();
         responses_checked <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            apply_request(rlfp_pkg::op_type'(req_operation),
                          rlfp_pkg::slot_type'(req_slot_index), req_newer_than, want);
            awaited_rsps.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            if (awaited_rsps.size() == 0) begin
               flag("response transfer with no request outstanding");
            end else begin
               want = awaited_rsps.pop_front();
               if (rsp_status !== want.status)
                  flag($sformatf("status %0d, expected %0d", rsp_status, want.status));
               if (rsp_granted_slot !== want.slot)
                  flag($sformatf("granted_slot %0d, expected %0d",
                                 rsp_granted_slot, want.slot));
               if (rsp_granted_seq !== want.seq)
                  flag($sformatf("granted_seq %0d, expected %0d",
                                 rsp_granted_seq, want.seq));
               if (rsp_slots_busy !== want.busy)
                  flag($sformatf("slots_busy %0d, expected %0d", rsp_slots_busy, want.busy));
               if (rsp_publishes_total !== want.pubs)
                  flag($sformatf("publishes_total %0d, expected %0d",
                                 rsp_publishes_total, want.pubs));
               if (rsp_acquire_misses !== want.misses)
                  flag($sformatf("acquire_misses %0d, expected %0d",
                                 rsp_acquire_misses, want.misses));
               responses_checked <= responses_checked + 1;
            end
         end
      end
   end

endmodule

`default_nettype wire

[dv/refcounted_latest_frame_pool_test.sv]
// ----------------------------------------------------------------------------
// refcounted_latest_frame_pool_test
// Drives directed and random pool operations in bursts against a stalling
// receiver; rlfp_monitor predicts and checks every response transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module refcounted_latest_frame_pool_test;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_operation = '0;
   logic [1:0]  req_slot_index = '0;
   logic [31:0] req_newer_than = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic [1:0]  rsp_granted_slot;
   logic [31:0] rsp_granted_seq;
   logic [2:0]  rsp_slots_busy;
   logic [31:0] rsp_publishes_total;
   logic [31:0] rsp_acquire_misses;

   int unsigned mismatches;
   int unsigned responses_checked;

   int unsigned       sent_total = 0;
   int unsigned       op_tally [4] = '{default: 0};
   int unsigned       burst_left = 0;
   rlfp_pkg::seq_type publishes_sent = '0;

   int unsigned stall_left = 0;
   int unsigned stall_mode = 0;

   always #6 clock = ~clock;

   refcounted_latest_frame_pool DUT (.*);

   rlfp_monitor monitor (.*);

   // receiver stall pattern: phases of no stall, light, heavy and alternating
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_left <= $urandom_range(20, 80);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= ~rsp_stall;
      endcase
   end

   task automatic issue(input rlfp_pkg::op_type op, input rlfp_pkg::slot_type idx,
                        input rlfp_pkg::seq_type nt);
      int unsigned gap;
      req_valid      <= 1'b1;
      req_operation  <= op;
      req_slot_index <= idx;
      req_newer_than <= nt;
      do @(posedge clock); while (req_stall);
      sent_total++;
      op_tally[op]++;
      if (op == rlfp_pkg::OP_PUBLISH)
         publishes_sent = publishes_sent + 32'd1;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
   endtask

   // thresholds around the current stamp hit both sides of the newer-than test
   function automatic rlfp_pkg::seq_type pick_newer();
      case ($urandom_range(0, 5))
         0, 1:    return '0;
         2:       return publishes_sent - 32'd1;
         3:       return publishes_sent;
         4:       return '1;
         default: return rlfp_pkg::seq_type'($urandom);
      endcase
   endfunction

   task automatic frame_cycle();
      int unsigned n;
      issue(rlfp_pkg::OP_ACQUIRE, rlfp_pkg::slot_type'($urandom),
            rlfp_pkg::seq_type'($urandom));
      issue(rlfp_pkg::OP_PUBLISH, rlfp_pkg::slot_type'($urandom),
            rlfp_pkg::seq_type'($urandom));
      n = $urandom_range(0, 3);
      repeat (n) issue(rlfp_pkg::OP_CLAIM, rlfp_pkg::slot_type'($urandom), pick_newer());
      n = $urandom_range(0, 3);
      repeat (n) issue(rlfp_pkg::OP_RELEASE, rlfp_pkg::slot_type'($urandom),
                       rlfp_pkg::seq_type'($urandom));
   endtask

   initial begin
      int unsigned directed_end;
      int unsigned storm_at;
      logic        storm_done;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty pool: nothing to claim, release underflows, first publish
      issue(rlfp_pkg::OP_CLAIM, rlfp_pkg::slot_type'(0), '0);
      issue(rlfp_pkg::OP_RELEASE, rlfp_pkg::slot_type'(0), '0);
      issue(rlfp_pkg::OP_PUBLISH, rlfp_pkg::slot_type'(2), '0);
      // fill every slot, then miss
      issue(rlfp_pkg::OP_ACQUIRE, rlfp_pkg::slot_type'(0), '0);
      issue(rlfp_pkg::OP_ACQUIRE, rlfp_pkg::slot_type'(3), '1);
      issue(rlfp_pkg::OP_ACQUIRE, rlfp_pkg::slot_type'(0), '0);
      issue(rlfp_pkg::OP_ACQUIRE, rlfp_pkg::slot_type'(0), '0);
      issue(rlfp_pkg::OP_ACQUIRE, rlfp_pkg::slot_type'(1), '0);
      issue(rlfp_pkg::OP_ACQUIRE, rlfp_pkg::slot_type'(2), '0);
      // republishing the latest slot drops its own count, then underflows
      issue(rlfp_pkg::OP_PUBLISH, rlfp_pkg::slot_type'(1), '0);
      issue(rlfp_pkg::OP_PUBLISH, rlfp_pkg::slot_type'(1), '0);
      issue(rlfp_pkg::OP_PUBLISH, rlfp_pkg::slot_type'(1), '1);
      issue(rlfp_pkg::OP_CLAIM, rlfp_pkg::slot_type'(3), '0);
      issue(rlfp_pkg::OP_CLAIM, rlfp_pkg::slot_type'(0), '1);
      issue(rlfp_pkg::OP_CLAIM, rlfp_pkg::slot_type'(0), publishes_sent - 32'd1);
      issue(rlfp_pkg::OP_CLAIM, rlfp_pkg::slot_type'(0), publishes_sent);
      issue(rlfp_pkg::OP_RELEASE, rlfp_pkg::slot_type'(3), '0);
      issue(rlfp_pkg::OP_RELEASE, rlfp_pkg::slot_type'(3), '0);
      issue(rlfp_pkg::OP_RELEASE, rlfp_pkg::slot_type'(0), '0);
      issue(rlfp_pkg::OP_RELEASE, rlfp_pkg::slot_type'(2), '0);
      issue(rlfp_pkg::OP_ACQUIRE, rlfp_pkg::slot_type'(0), '0);
      issue(rlfp_pkg::OP_PUBLISH, rlfp_pkg::slot_type'(3), '0);
      issue(rlfp_pkg::OP_CLAIM, rlfp_pkg::slot_type'(1), '0);
      directed_end = sent_total;

      storm_at   = directed_end + $urandom_range(150, 350);
      storm_done = 1'b0;
      while (sent_total < directed_end + 600) begin
         if (!storm_done && sent_total >= storm_at) begin
            // drive one slot's count into saturation
            issue(rlfp_pkg::OP_PUBLISH, rlfp_pkg::slot_type'($urandom), '0);
            repeat (258) issue(rlfp_pkg::OP_CLAIM, rlfp_pkg::slot_type'($urandom), '0);
            storm_done = 1'b1;
         end else if ($urandom_range(0, 4) == 0) begin
            issue(rlfp_pkg::op_type'($urandom_range(0, 3)), rlfp_pkg::slot_type'($urandom),
                  ($urandom_range(0, 1) == 0) ? pick_newer()
                                              : rlfp_pkg::seq_type'($urandom));
         end else begin
            frame_cycle();
         end
      end
      req_valid <= 1'b0;

      while (responses_checked != sent_total) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Sent %0d requests: %0d acquire, %0d publish, %0d claim, %0d release",
               sent_total, op_tally[rlfp_pkg::OP_ACQUIRE], op_tally[rlfp_pkg::OP_PUBLISH],
               op_tally[rlfp_pkg::OP_CLAIM], op_tally[rlfp_pkg::OP_RELEASE]);
      $display("Checked %0d responses, incl. a claim run past the count limit",
               responses_checked);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #2400000;
      $display("Timed out waiting for responses");
      $display("Mismatches found");
      $finish;
   end

endmodule

`default_nettype wire
